@@ hdl/dkda_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Direction key debounce package
// Shared codes, widths, register indexes and types of the direction key block.
// ----------------------------------------------------------------------------
package dkda_pkg;

  localparam int STICK_W    = 8;
  localparam int DIR_W      = 3;
  localparam int THRESH_W   = 7;
  localparam int DEBOUNCE_W = 8;
  localparam int REPEAT_W   = 12;
  localparam int STEADY_W   = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [DIR_W-1:0] CODE_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] CODE_UP    = 3'd1;
  localparam logic [DIR_W-1:0] CODE_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] CODE_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] CODE_RIGHT = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_STICK_THRESHOLD    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_FIRST_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_NEXT_TICKS  = 2'd3;

  localparam logic [THRESH_W-1:0]   RST_STICK_THRESHOLD    = 7'd60;
  localparam logic [DEBOUNCE_W-1:0] RST_DEBOUNCE_TICKS     = 8'd30;
  localparam logic [REPEAT_W-1:0]   RST_REPEAT_FIRST_TICKS = 12'd450;
  localparam logic [REPEAT_W-1:0]   RST_REPEAT_NEXT_TICKS  = 12'd150;

  typedef struct packed {
    logic signed [STICK_W-1:0] stick_x;
    logic signed [STICK_W-1:0] stick_y;
    logic                      key_up;
    logic                      key_down;
    logic                      key_left;
    logic                      key_right;
  } sample_t;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0] debounce_ticks;
    logic [REPEAT_W-1:0]   repeat_first_ticks;
    logic [REPEAT_W-1:0]   repeat_next_ticks;
  } timing_cfg_t;

endpackage

`default_nettype wire

@@ hdl/dkda_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Direction key channel interfaces
// Valid/ready channels for the input samples and the direction results.
// ----------------------------------------------------------------------------
interface dkda_in_if
  import dkda_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic signed [STICK_W-1:0] stick_x;
  logic signed [STICK_W-1:0] stick_y;
  logic                      key_up;
  logic                      key_down;
  logic                      key_left;
  logic                      key_right;

  modport source (
    output valid, stick_x, stick_y, key_up, key_down, key_left, key_right,
    input  ready
  );
  modport sink (
    input  valid, stick_x, stick_y, key_up, key_down, key_left, key_right,
    output ready
  );
endinterface

interface dkda_out_if
  import dkda_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [DIR_W-1:0] direction_event;

  modport source (
    output valid, direction_event,
    input  ready
  );
  modport sink (
    input  valid, direction_event,
    output ready
  );
endinterface

`default_nettype wire

@@ hdl/dkda_encode.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Direction priority encoder
// Turns one registered sample into a raw direction code, up first.
// ----------------------------------------------------------------------------
module dkda_encode
  import dkda_pkg::*;
(
  input  var sample_t             sample,
  input  wire [THRESH_W-1:0]      stick_threshold,
  output logic [DIR_W-1:0]        raw_code
);

  logic signed [STICK_W:0] x_ext;
  logic signed [STICK_W:0] y_ext;
  logic signed [STICK_W:0] th_pos;
  logic signed [STICK_W:0] th_neg;

  assign x_ext  = {sample.stick_x[STICK_W-1], sample.stick_x};
  assign y_ext  = {sample.stick_y[STICK_W-1], sample.stick_y};
  assign th_pos = {{(STICK_W + 1 - THRESH_W){1'b0}}, stick_threshold};
  assign th_neg = -th_pos;

  always_comb begin
    if (sample.key_up || (y_ext > th_pos)) begin
      raw_code = CODE_UP;
    end else if (sample.key_down || (y_ext < th_neg)) begin
      raw_code = CODE_DOWN;
    end else if (sample.key_left || (x_ext < th_neg)) begin
      raw_code = CODE_LEFT;
    end else if (sample.key_right || (x_ext > th_pos)) begin
      raw_code = CODE_RIGHT;
    end else begin
      raw_code = CODE_NONE;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dkda_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Debounce and auto-repeat core
// Holds the debounce and repeat state and the result register.
// ----------------------------------------------------------------------------
module dkda_core
  import dkda_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 sample_valid,
  input  wire [DIR_W-1:0]     raw_code,
  input  var timing_cfg_t     timing_cfg,
  output logic                step,
  dkda_out_if.source          out_ch
);

  logic [DIR_W-1:0]    last_raw_r,   last_raw_nxt;
  logic [STEADY_W-1:0] steady_r,     steady_nxt;
  logic [DIR_W-1:0]    stable_r,     stable_nxt;
  logic [REPEAT_W-1:0] countdown_r,  countdown_nxt;
  logic                out_valid_r;
  logic [DIR_W-1:0]    event_r,      event_nxt;
  logic [REPEAT_W-1:0] countdown_dec;

  assign step = sample_valid && (!out_valid_r || out_ch.ready);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.direction_event = event_r;

  always_comb begin
    countdown_dec = (countdown_r != '0) ? countdown_r - 1'b1 : countdown_r;
    last_raw_nxt  = raw_code;
    if (raw_code != last_raw_r) begin
      steady_nxt = '0;
    end else if (steady_r != '1) begin
      steady_nxt = steady_r + 1'b1;
    end else begin
      steady_nxt = steady_r;
    end
    stable_nxt    = stable_r;
    countdown_nxt = countdown_dec;
    event_nxt     = CODE_NONE;
    if (steady_nxt >= {1'b0, timing_cfg.debounce_ticks}) begin
      if (raw_code != stable_r) begin
        stable_nxt = raw_code;
        if (raw_code != CODE_NONE) begin
          countdown_nxt = timing_cfg.repeat_first_ticks;
          event_nxt     = raw_code;
        end
      end else if ((raw_code != CODE_NONE) && (countdown_dec == '0)) begin
        countdown_nxt = timing_cfg.repeat_next_ticks;
        event_nxt     = raw_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r  <= CODE_NONE;
      steady_r    <= '0;
      stable_r    <= CODE_NONE;
      countdown_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        last_raw_r  <= last_raw_nxt;
        steady_r    <= steady_nxt;
        stable_r    <= stable_nxt;
        countdown_r <= countdown_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      event_r <= event_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/direction_key_debounce_autorepeat.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Direction key debounce with auto-repeat
// Debounces four direction buttons and a stick and emits typematic events.
// ----------------------------------------------------------------------------
// Each request on in_ch is one millisecond sample of the direction buttons
// and the stick. Every request yields exactly one result on out_ch: a
// direction code, or none when nothing is to be reported.
// A sample is taken into the input register, encoded and run through the
// debounce and repeat state, and the result is held in the output
// register. One request is accepted every cycle while out_ch does not
// stall; the debounce and repeat state is updated once per request, which
// sets that rate. While out_ch stalls, the result register holds its value
// and the input register takes one more request if it is empty, after
// which in_ch.ready falls. The cfg port writes one timing register per
// cycle; it is to be written only while the block holds no request, which
// the block does not enforce. Synchronous reset restores the default
// threshold and delays and clears the debounce and repeat state.
// ----------------------------------------------------------------------------
module direction_key_debounce_autorepeat
  import dkda_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,
  dkda_in_if.sink              in_ch,
  dkda_out_if.source           out_ch,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  logic [THRESH_W-1:0] threshold_r;
  timing_cfg_t         timing_r;
  logic                sample_valid_r;
  sample_t             sample_r;
  logic [DIR_W-1:0]    raw_code;
  logic                step;

  assign in_ch.ready = !sample_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r                 <= RST_STICK_THRESHOLD;
      timing_r.debounce_ticks     <= RST_DEBOUNCE_TICKS;
      timing_r.repeat_first_ticks <= RST_REPEAT_FIRST_TICKS;
      timing_r.repeat_next_ticks  <= RST_REPEAT_NEXT_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_STICK_THRESHOLD:    threshold_r <= cfg_data[THRESH_W-1:0];
        REG_DEBOUNCE_TICKS:     timing_r.debounce_ticks <= cfg_data[DEBOUNCE_W-1:0];
        REG_REPEAT_FIRST_TICKS: timing_r.repeat_first_ticks <= cfg_data[REPEAT_W-1:0];
        REG_REPEAT_NEXT_TICKS:  timing_r.repeat_next_ticks <= cfg_data[REPEAT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      sample_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r.stick_x   <= in_ch.stick_x;
      sample_r.stick_y   <= in_ch.stick_y;
      sample_r.key_up    <= in_ch.key_up;
      sample_r.key_down  <= in_ch.key_down;
      sample_r.key_left  <= in_ch.key_left;
      sample_r.key_right <= in_ch.key_right;
    end
  end

  dkda_encode u_encode (
    .sample          (sample_r),
    .stick_threshold (threshold_r),
    .raw_code        (raw_code)
  );

  dkda_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid_r),
    .raw_code     (raw_code),
    .timing_cfg   (timing_r),
    .step         (step),
    .out_ch       (out_ch)
  );

endmodule

`default_nettype wire

@@ tb/direction_key_debounce_autorepeat_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Direction key debounce and auto-repeat testbench
// Drives millisecond samples of the direction buttons and the stick into the
// block and predicts every direction event in step with accepted requests.
// It covers a short directed run and randomized button holds with glitches
// and noise, across several threshold and delay settings and idle patterns.
// ----------------------------------------------------------------------------
module direction_key_debounce_autorepeat_tb;
  import dkda_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SAMPLE_W    = $bits(sample_t);

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dkda_in_if  in_ch();
  dkda_out_if out_ch();

  direction_key_debounce_autorepeat DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [THRESH_W-1:0]   thr_cfg   = RST_STICK_THRESHOLD;
  logic [DEBOUNCE_W-1:0] deb_cfg   = RST_DEBOUNCE_TICKS;
  logic [REPEAT_W-1:0]   first_cfg = RST_REPEAT_FIRST_TICKS;
  logic [REPEAT_W-1:0]   next_cfg  = RST_REPEAT_NEXT_TICKS;

  logic [DIR_W-1:0]    raw_prev   = CODE_NONE;
  logic [STEADY_W-1:0] steady_cnt = '0;
  logic [DIR_W-1:0]    stable_dir = CODE_NONE;
  logic [REPEAT_W-1:0] repeat_cnt = '0;

  sample_t          pending_samples[$];
  logic [DIR_W-1:0] expected_dirs[$];
  int               send_idle_pct  = 0;
  int               recv_stall_pct = 0;
  int               mismatch_count = 0;
  int               cycle_count    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DIR_W-1:0] debounce_step(sample_t s);
    int               sx;
    int               sy;
    int               th;
    logic [DIR_W-1:0] raw;
    logic [DIR_W-1:0] ev;
    sx = $signed(s.stick_x);
    sy = $signed(s.stick_y);
    th = int'(thr_cfg);
    if (s.key_up || sy > th) raw = CODE_UP;
    else if (s.key_down || sy < -th) raw = CODE_DOWN;
    else if (s.key_left || sx < -th) raw = CODE_LEFT;
    else if (s.key_right || sx > th) raw = CODE_RIGHT;
    else raw = CODE_NONE;
    ev = CODE_NONE;
    if (repeat_cnt != '0) repeat_cnt = repeat_cnt - 1'b1;
    if (raw != raw_prev) begin
      raw_prev   = raw;
      steady_cnt = '0;
    end else if (steady_cnt != '1) begin
      steady_cnt = steady_cnt + 1'b1;
    end
    if (steady_cnt >= STEADY_W'(deb_cfg)) begin
      if (raw != stable_dir) begin
        stable_dir = raw;
        if (raw != CODE_NONE) begin
          repeat_cnt = first_cfg;
          ev         = raw;
        end
      end else if (raw != CODE_NONE && repeat_cnt == '0) begin
        repeat_cnt = next_cfg;
        ev         = raw;
      end
    end
    return ev;
  endfunction

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic sample_t pack_sample(int x, int y, bit up, bit down, bit left, bit right);
    sample_t s;
    s.stick_x   = STICK_W'(x);
    s.stick_y   = STICK_W'(y);
    s.key_up    = up;
    s.key_down  = down;
    s.key_left  = left;
    s.key_right = right;
    return s;
  endfunction

  // Builds a random sample whose priority encoding under the threshold is dir.
  function automatic sample_t make_sample(logic [DIR_W-1:0] dir, logic [THRESH_W-1:0] thr);
    sample_t             s;
    logic [SAMPLE_W-1:0] bits_v;
    int                  th;
    th     = int'(thr);
    bits_v = SAMPLE_W'($urandom());
    s      = bits_v;
    case (dir)
      CODE_UP: begin
        if (th == 127 || $urandom_range(1) == 0) s.key_up = 1'b1;
        else s.stick_y = STICK_W'(rand_in(th + 1, 127));
      end
      CODE_DOWN: begin
        s.key_up = 1'b0;
        if ($urandom_range(1) == 0) begin
          s.key_down = 1'b1;
          s.stick_y  = STICK_W'(rand_in(-128, th));
        end else begin
          s.stick_y = STICK_W'(rand_in(-128, -th - 1));
        end
      end
      CODE_LEFT: begin
        {s.key_up, s.key_down} = 2'b00;
        s.stick_y = STICK_W'(rand_in(-th, th));
        if ($urandom_range(1) == 0) s.key_left = 1'b1;
        else s.stick_x = STICK_W'(rand_in(-128, -th - 1));
      end
      CODE_RIGHT: begin
        {s.key_up, s.key_down, s.key_left} = 3'b000;
        s.stick_y = STICK_W'(rand_in(-th, th));
        if (th == 127 || $urandom_range(1) == 0) begin
          s.key_right = 1'b1;
          s.stick_x   = STICK_W'(rand_in(-th, 127));
        end else begin
          s.stick_x = STICK_W'(rand_in(th + 1, 127));
        end
      end
      default: begin
        {s.key_up, s.key_down, s.key_left, s.key_right} = 4'b0000;
        s.stick_x = STICK_W'(rand_in(-th, th));
        s.stick_y = STICK_W'(rand_in(-th, th));
      end
    endcase
    return s;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width,
                           input bit junk);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    if (junk) data = data | CFG_DATA_W'($urandom() << width);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_STICK_THRESHOLD:    thr_cfg   = data[THRESH_W-1:0];
      REG_DEBOUNCE_TICKS:     deb_cfg   = data[DEBOUNCE_W-1:0];
      REG_REPEAT_FIRST_TICKS: first_cfg = data[REPEAT_W-1:0];
      REG_REPEAT_NEXT_TICKS:  next_cfg  = data[REPEAT_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic set_timing(input int thr, input int deb, input int first, input int nxt,
                            input bit junk);
    write_reg(REG_STICK_THRESHOLD, thr, THRESH_W, junk);
    write_reg(REG_DEBOUNCE_TICKS, deb, DEBOUNCE_W, junk);
    write_reg(REG_REPEAT_FIRST_TICKS, first, REPEAT_W, junk);
    write_reg(REG_REPEAT_NEXT_TICKS, nxt, REPEAT_W, junk);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Holds the sender until every request is accepted and every event returned.
  task automatic drain();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_ch.valid || expected_dirs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Mostly button holds of random length with the odd glitch, plus bursts of noise.
  task automatic queue_holds(input int budget);
    int                  left_items;
    int                  len;
    int                  kind;
    int                  deb;
    logic [DIR_W-1:0]    dir;
    sample_t             s;
    logic [SAMPLE_W-1:0] bits_v;
    left_items = budget;
    deb        = int'(deb_cfg);
    while (left_items > 0) begin
      dir  = DIR_W'($urandom_range(CODE_RIGHT, CODE_NONE));
      kind = $urandom_range(99);
      if (kind < 10) len = $urandom_range(8, 1);
      else if (kind < 35) len = $urandom_range(deb + 2, 1);
      else if (kind < 40) len = $urandom_range(700, 520);
      else len = deb + $urandom_range(int'(first_cfg) + 3 * int'(next_cfg) + 2, 1);
      if (len > 700) len = 700;
      if (len > left_items) len = left_items;
      for (int k = 0; k < len; k++) begin
        if (kind < 10) begin
          bits_v = SAMPLE_W'($urandom());
          s      = bits_v;
        end else if ($urandom_range(99) < 3) begin
          s = make_sample(DIR_W'($urandom_range(CODE_RIGHT, CODE_NONE)), thr_cfg);
        end else begin
          s = make_sample(dir, thr_cfg);
        end
        pending_samples.push_back(s);
      end
      left_items -= len;
    end
  endtask

  task automatic run_holds(input int thr, input int deb, input int first, input int nxt,
                           input bit junk, input int send_pct, input int recv_pct,
                           input int budget);
    set_timing(thr, deb, first, nxt, junk);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    queue_holds(budget);
    drain();
  endtask

  always @(posedge clk) begin : driver
    sample_t req;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_dirs.push_back(debounce_step(sample_t'({in_ch.stick_x, in_ch.stick_y,
            in_ch.key_up, in_ch.key_down, in_ch.key_left, in_ch.key_right})));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_samples.pop_front();
          {in_ch.stick_x, in_ch.stick_y, in_ch.key_up, in_ch.key_down, in_ch.key_left,
           in_ch.key_right} <= req;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_dirs.size() == 0) begin
        $error("direction_event: expected nothing, actual %0d", out_ch.direction_event);
        mismatch_count++;
      end else begin
        if (out_ch.direction_event !== expected_dirs[0]) begin
          $error("direction_event: expected %0d, actual %0d", expected_dirs[0],
                 out_ch.direction_event);
          mismatch_count++;
        end
        void'(expected_dirs.pop_front());
      end
    end
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = REG_STICK_THRESHOLD;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.stick_x   = '0;
    in_ch.stick_y   = '0;
    in_ch.key_up    = 1'b0;
    in_ch.key_down  = 1'b0;
    in_ch.key_left  = 1'b0;
    in_ch.key_right = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // With no debounce and a zero next repeat delay, every tick shows its effect.
    set_timing(60, 0, 3, 0, 1'b0);
    @(negedge clk);
    pending_samples.push_back(pack_sample(0, 0, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(127, 127, 1, 1, 1, 1));
    pending_samples.push_back(pack_sample(-128, -128, 0, 1, 1, 1));
    pending_samples.push_back(pack_sample(127, 0, 0, 0, 1, 0));
    pending_samples.push_back(pack_sample(0, 0, 0, 0, 0, 1));
    pending_samples.push_back(pack_sample(0, 61, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(0, 60, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(0, -60, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(0, -61, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(-61, 0, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(-60, 60, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(61, 0, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(60, -60, 0, 0, 0, 0));
    for (int k = 0; k < 6; k++) pending_samples.push_back(pack_sample(127, 0, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(-128, 0, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(0, 127, 0, 0, 0, 0));
    pending_samples.push_back(pack_sample(0, 0, 0, 0, 0, 0));
    drain();

    run_holds(60, 3, 8, 4, 1'b0, 0, 0, 300);
    run_holds(0, 0, 1, 1, 1'b0, 59, 0, 200);
    run_holds(90, 255, 60, 20, 1'b0, 0, 59, 450);
    run_holds(30, 10, 20, 5, 1'b0, 16, 16, 300);
    run_holds(100, 1, 2, 0, 1'b1, 0, 0, 150);
    run_holds(127, 255, 4095, 4095, 1'b0, 16, 16, 250);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && expected_dirs.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
